// ----- hw/rtl/kpsc_pkg.sv -----
`timescale 1ns / 1ps

package kpsc_pkg;

    localparam int KEY_COUNT   = 16;
    localparam int SCAN_W      = 16;
    localparam int CODE_W      = 7;
    localparam int VERDICT_W   = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 32;

    // Queue between the front and the back part.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_SECOND = 2'd1;

    localparam logic [CODE_W-1:0] RESET_CODE_FIRST  = 7'd51;  // '3'
    localparam logic [CODE_W-1:0] RESET_CODE_SECOND = 7'd53;  // '5'
    localparam logic [CODE_W-1:0] NO_KEY_CODE       = 7'd0;

    localparam logic [VERDICT_W-1:0] VERDICT_NONE     = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_FIRST    = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_MATCH    = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_MISMATCH = 2'd3;

    // One classified scan waiting for the code check.
    typedef struct packed {
        logic [SCAN_W-1:0] fresh_mask;
        logic [CODE_W-1:0] key_code;
    } kpsc_entry_t;

    // Read side of the queue as seen by the back part.
    typedef struct packed {
        logic        valid;
        kpsc_entry_t entry;
    } kpsc_q_rd_t;

    // Keypad legend: row 0 "123A", row 1 "456B", row 2 "789C", row 3 "*0#D".
    function automatic logic [CODE_W-1:0] key_ascii(input logic [3:0] idx);
        logic [CODE_W-1:0] c;
        unique case (idx)
            4'd0:    c = 7'h31;
            4'd1:    c = 7'h32;
            4'd2:    c = 7'h33;
            4'd3:    c = 7'h41;
            4'd4:    c = 7'h34;
            4'd5:    c = 7'h35;
            4'd6:    c = 7'h36;
            4'd7:    c = 7'h42;
            4'd8:    c = 7'h37;
            4'd9:    c = 7'h38;
            4'd10:   c = 7'h39;
            4'd11:   c = 7'h43;
            4'd12:   c = 7'h2A;
            4'd13:   c = 7'h30;
            4'd14:   c = 7'h23;
            default: c = 7'h44;
        endcase
        return c;
    endfunction

    // Lowest set bit wins: the row is found first, then the column within it.
    function automatic logic [CODE_W-1:0] encode_first_key(input logic [SCAN_W-1:0] mask);
        logic [1:0] row;
        logic [1:0] col;
        logic [3:0] row_bits;
        row = 2'd0;
        col = 2'd0;
        for (int r = 3; r >= 0; r--) begin
            if (mask[4*r +: 4] != 4'd0) begin
                row = 2'(r);
            end
        end
        row_bits = mask[4*row +: 4];
        for (int c = 3; c >= 0; c--) begin
            if (row_bits[c]) begin
                col = 2'(c);
            end
        end
        if (mask == '0) begin
            return NO_KEY_CODE;
        end
        return key_ascii({row, col});
    endfunction

endpackage

// ----- hw/rtl/kpsc_front.sv -----
`timescale 1ns / 1ps

module kpsc_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kpsc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             q_full,
    output logic                             q_push,
    output kpsc_pkg::kpsc_entry_t            q_push_entry
);
    import kpsc_pkg::*;

    logic [SCAN_W-1:0] previous_mask_reg;
    logic [SCAN_W-1:0] previous_mask_next;
    logic [SCAN_W-1:0] debounced;
    logic [SCAN_W-1:0] fresh;

    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && s_tready;

    // A key counts only if both snapshots see it and it was not down last time.
    assign debounced = s_tdata[SCAN_W-1:0] & s_tdata[2*SCAN_W-1:SCAN_W];
    assign fresh     = debounced & ~previous_mask_reg;

    assign q_push_entry.fresh_mask = fresh;
    assign q_push_entry.key_code   = encode_first_key(fresh);

    assign previous_mask_next = q_push ? debounced : previous_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            previous_mask_reg <= '0;
        end else begin
            previous_mask_reg <= previous_mask_next;
        end
    end

endmodule

// ----- hw/rtl/kpsc_queue.sv -----
`timescale 1ns / 1ps

module kpsc_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  kpsc_pkg::kpsc_entry_t  push_entry,
    output logic                   full,
    input  logic                   pop,
    output kpsc_pkg::kpsc_q_rd_t   rd
);
    import kpsc_pkg::*;

    kpsc_entry_t       mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.entry = mem_reg[rd_ptr_reg];
    assign do_pop   = pop && rd.valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/kpsc_back.sv -----
`timescale 1ns / 1ps

module kpsc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [kpsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [kpsc_pkg::CODE_W-1:0]       cfg_wdata,
    input  kpsc_pkg::kpsc_q_rd_t              q_rd,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kpsc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import kpsc_pkg::*;

    logic [CODE_W-1:0]    code_first_reg;
    logic [CODE_W-1:0]    code_second_reg;
    logic                 awaiting_second_reg;
    logic                 awaiting_second_next;
    logic [CODE_W-1:0]    held_first_key_reg;
    logic [CODE_W-1:0]    held_first_key_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [SCAN_W-1:0]    out_mask_reg;
    logic [CODE_W-1:0]    out_code_reg;
    logic [VERDICT_W-1:0] out_verdict_reg;
    logic [VERDICT_W-1:0] verdict;
    logic                 has_press;

    // The output register is refilled whenever it is empty or being emptied.
    assign q_pop     = q_rd.valid && (!out_valid_reg || m_tready);
    assign has_press = (q_rd.entry.fresh_mask != '0);

    always_comb begin
        verdict              = VERDICT_NONE;
        awaiting_second_next = awaiting_second_reg;
        held_first_key_next  = held_first_key_reg;
        if (q_pop && has_press) begin
            if (!awaiting_second_reg) begin
                held_first_key_next  = q_rd.entry.key_code;
                awaiting_second_next = 1'b1;
                verdict              = VERDICT_FIRST;
            end else begin
                awaiting_second_next = 1'b0;
                if (held_first_key_reg == code_first_reg &&
                    q_rd.entry.key_code == code_second_reg) begin
                    verdict = VERDICT_MATCH;
                end else begin
                    verdict = VERDICT_MISMATCH;
                end
            end
        end
        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_first_reg      <= RESET_CODE_FIRST;
            code_second_reg     <= RESET_CODE_SECOND;
            awaiting_second_reg <= 1'b0;
            held_first_key_reg  <= NO_KEY_CODE;
            out_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_CODE_FIRST) begin
                code_first_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_CODE_SECOND) begin
                code_second_reg <= cfg_wdata;
            end
            awaiting_second_reg <= awaiting_second_next;
            held_first_key_reg  <= held_first_key_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_mask_reg    <= q_rd.entry.fresh_mask;
            out_code_reg    <= q_rd.entry.key_code;
            out_verdict_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - SCAN_W - 1 - CODE_W - VERDICT_W){1'b0}},
                       out_verdict_reg, out_code_reg, (out_mask_reg != '0), out_mask_reg};

endmodule

// ----- hw/rtl/keypad_edge_scanner_pin_check_top.sv -----
`timescale 1ns / 1ps
// Keypad scanner with debounce, new-press detection and a two-key code check.
// Input stream (s_*): one transaction carries two 16-bit keypad snapshots taken
// one debounce interval apart; every input transaction yields exactly one
// output transaction (m_*) with the new-press mask, a press flag, the ASCII
// code of the first new key and the verdict of the code check.
// Configuration: cfg_we with cfg_index 0 writes the expected first key, index 1
// the expected second key; other indexes are ignored. Write only while idle.
// Throughput is one transaction per cycle while the queue is not full and the
// receiver keeps m_tready high. Each accepted scan is first classified and
// queued, then run through the code check into the output register.
// A four-entry queue sits between the two parts; when the receiver holds
// m_tready low the output register holds its transaction, the queue fills and
// s_tready falls once all four entries are taken.
// Reset (aresetn low, synchronous) empties the queue and output register,
// clears the stored previous mask and code check state and restores the
// code keys to '3' and '5'.
module keypad_edge_scanner_pin_check_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] first_scan, [31:16] second_scan
    input  logic [kpsc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] new_press_mask, [16] any_new_press, [23:17] key_code,
    // [25:24] verdict, [31:26] zero
    output logic [kpsc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [kpsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [kpsc_pkg::CODE_W-1:0]       cfg_wdata
);
    import kpsc_pkg::*;

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    kpsc_entry_t q_push_entry;
    kpsc_q_rd_t  q_rd;

    kpsc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_push_entry (q_push_entry)
    );

    kpsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .rd         (q_rd)
    );

    kpsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_rd      (q_rd),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A verdict is given exactly when some key is newly pressed.
    a_verdict_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[25:24] == VERDICT_NONE) == (m_tdata[15:0] == 16'd0)))
        else $error("verdict disagrees with new-press mask");

    // Without a new press the key code must be zero.
    a_code_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[16]) |-> (m_tdata[23:17] == NO_KEY_CODE))
        else $error("key code set without a new press");

    // A queue entry is never pushed while the queue is full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("push into a full queue");

    // Nothing is offered in the first cycle after reset is released.
    a_reset_idle: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("output valid straight after reset");

endmodule

// ----- verif/keypad_edge_scanner_pin_check_top_tb.sv -----
`timescale 1ns / 1ps

module keypad_edge_scanner_pin_check_top_tb;
    import kpsc_pkg::*;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 245;

    // The block ignores writes to these two indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int ANY_POS     = SCAN_W;
    localparam int KEY_POS     = ANY_POS + 1;
    localparam int VERDICT_POS = KEY_POS + CODE_W;
    localparam int PAD_POS     = VERDICT_POS + VERDICT_W;

    localparam logic [CODE_W-1:0] KEYPAD_LEGEND [KEY_COUNT] = '{
        7'h31, 7'h32, 7'h33, 7'h41,
        7'h34, 7'h35, 7'h36, 7'h42,
        7'h37, 7'h38, 7'h39, 7'h43,
        7'h2A, 7'h30, 7'h23, 7'h44
    };

    typedef struct packed {
        logic [SCAN_W-1:0]    new_press_mask;
        logic                 any_new_press;
        logic [CODE_W-1:0]    key_code;
        logic [VERDICT_W-1:0] verdict;
    } press_report_t;

    class keypad_press_scoreboard;
        logic [CODE_W-1:0] code_first;
        logic [CODE_W-1:0] code_second;
        logic [SCAN_W-1:0] prev_mask;
        logic [CODE_W-1:0] held_key;
        bit                awaiting;
        press_report_t     expected_reports[$];
        int unsigned       failures;

        function new();
            code_first  = RESET_CODE_FIRST;
            code_second = RESET_CODE_SECOND;
            prev_mask   = '0;
            held_key    = '0;
            awaiting    = 1'b0;
            failures    = 0;
        endfunction

        function void write_code(input logic [CFG_INDEX_W-1:0] index,
                                 input logic [CODE_W-1:0] value);
            if (index == CFG_CODE_FIRST) begin
                code_first = value;
            end else if (index == CFG_CODE_SECOND) begin
                code_second = value;
            end
        endfunction

        function void note_scan(input logic [SCAN_W-1:0] scan_a,
                                input logic [SCAN_W-1:0] scan_b);
            logic [SCAN_W-1:0] debounced;
            press_report_t     r;
            debounced        = scan_a & scan_b;
            r.new_press_mask = debounced & ~prev_mask;
            r.any_new_press  = |r.new_press_mask;
            r.key_code       = NO_KEY_CODE;
            // Walk downwards so that the lowest set bit has the last word.
            for (int k = KEY_COUNT - 1; k >= 0; k--) begin
                if (r.new_press_mask[k]) begin
                    r.key_code = KEYPAD_LEGEND[k];
                end
            end
            r.verdict = VERDICT_NONE;
            prev_mask = debounced;
            if (r.any_new_press) begin
                if (!awaiting) begin
                    held_key  = r.key_code;
                    awaiting  = 1'b1;
                    r.verdict = VERDICT_FIRST;
                end else begin
                    r.verdict = (held_key == code_first && r.key_code == code_second) ?
                                VERDICT_MATCH : VERDICT_MISMATCH;
                    awaiting  = 1'b0;
                end
            end
            expected_reports.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(input logic [M_TDATA_W-1:0] word);
            press_report_t want;
            if (expected_reports.size() == 0) begin
                $display("%0t: result %h expected none, got one", $time, word);
                failures++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("new_press_mask", 32'(want.new_press_mask), 32'(word[SCAN_W-1:0]));
            compare_field("any_new_press", 32'(want.any_new_press), 32'(word[ANY_POS]));
            compare_field("key_code", 32'(want.key_code), 32'(word[KEY_POS +: CODE_W]));
            compare_field("verdict", 32'(want.verdict), 32'(word[VERDICT_POS +: VERDICT_W]));
            compare_field("padding", 32'd0, 32'(word[M_TDATA_W-1:PAD_POS]));
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CODE_W-1:0]      cfg_wdata = '0;

    keypad_press_scoreboard sb = new();

    bit                burst      = 1'b0;
    bit                tap_parity = 1'b0;
    logic [SCAN_W-1:0] held_keys  = '0;

    keypad_edge_scanner_pin_check_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Inputs are noted before results are checked, so ordering within an edge is fixed.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_scan(s_tdata[SCAN_W-1:0], s_tdata[2*SCAN_W-1:SCAN_W]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
        end
    end

    function automatic int unsigned draw_gap();
        return burst ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic send_scan(input logic [SCAN_W-1:0] scan_a, input logic [SCAN_W-1:0] scan_b);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {scan_b, scan_a};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CODE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.write_code(index, value);
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        // One edge first, so that the last transaction has been noted.
        @(posedge aclk);
        while (sb.expected_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Half are clean key taps aimed at the configured code, with bounce on one
    // snapshot; the rest are releases, held keys and raw noise.
    task automatic send_random_scan();
        logic [SCAN_W-1:0] a;
        logic [SCAN_W-1:0] b;
        logic [SCAN_W-1:0] bounce;
        logic [CODE_W-1:0] target;
        int unsigned       kind;
        int unsigned       k;
        kind   = $urandom_range(0, 9);
        bounce = SCAN_W'($urandom);
        if (kind <= 4) begin
            target     = tap_parity ? sb.code_second : sb.code_first;
            tap_parity = ~tap_parity;
            k          = $urandom_range(0, KEY_COUNT - 1);
            if ($urandom_range(0, 9) < 6) begin
                for (int i = 0; i < KEY_COUNT; i++) begin
                    if (KEYPAD_LEGEND[i] == target) begin
                        k = i;
                    end
                end
            end
            a = SCAN_W'(1) << k;
            if ($urandom_range(0, 3) == 0) begin
                a |= held_keys;
            end
            b         = a;
            held_keys = a;
            if ($urandom_range(0, 1) == 1) begin
                a |= bounce;
            end else begin
                b |= bounce;
            end
        end else if (kind <= 6) begin
            a         = ($urandom_range(0, 3) == 0) ? (held_keys & bounce) : '0;
            b         = a;
            held_keys = a;
        end else if (kind == 7) begin
            a = held_keys;
            b = held_keys;
        end else begin
            a         = SCAN_W'($urandom);
            b         = SCAN_W'($urandom);
            held_keys = a & b;
        end
        send_scan(a, b);
    endtask

    initial begin
        int unsigned gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        int unsigned k;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, run with the code keys left at their reset values.
        send_scan(16'h0000, 16'h0000);
        send_scan(16'h0004, 16'h0004);
        send_scan(16'h0004, 16'h0004);
        send_scan(16'h0000, 16'h0000);
        send_scan(16'h0020, 16'h0020);
        send_scan(16'hFFFF, 16'h0000);
        send_scan(16'hFFFF, 16'hFFFF);
        send_scan(16'hFFFF, 16'hFFFF);
        send_scan(16'h7FFF, 16'hFFFF);
        send_scan(16'h0000, 16'h0000);
        send_scan(16'h8000, 16'h8000);
        send_scan(16'hAAAA, 16'h5555);
        send_scan(16'h0F00, 16'h0300);
        send_scan(16'hF000, 16'hF000);
        send_scan(16'h0000, 16'h0000);
        send_scan(16'h0004, 16'h0014);
        send_scan(16'h0024, 16'h0024);
        send_scan(16'h0000, 16'h0000);
        send_scan(16'h0004, 16'hFFFF);
        send_scan(16'h002C, 16'h002C);
        send_scan(16'h0000, 16'h0000);
        send_scan(16'h0004, 16'h0004);
        send_scan(16'h0000, 16'h0000);
        send_scan(16'h0020, 16'h0020);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_CODE_FIRST, 7'h00);
                    write_reg(CFG_CODE_SECOND, 7'h00);
                end
                1: begin
                    write_reg(CFG_CODE_FIRST, 7'h7F);
                    write_reg(CFG_CODE_SECOND, 7'h7F);
                end
                2: begin
                    write_reg(CFG_CODE_FIRST, 7'h2A);
                    write_reg(CFG_CODE_SECOND, 7'h23);
                end
                3: begin
                    write_reg(CFG_CODE_FIRST, KEYPAD_LEGEND[$urandom_range(0, KEY_COUNT - 1)]);
                    write_reg(CFG_CODE_SECOND, KEYPAD_LEGEND[$urandom_range(0, KEY_COUNT - 1)]);
                end
                4: begin
                    // The same key twice makes a valid code as well.
                    k = $urandom_range(0, KEY_COUNT - 1);
                    write_reg(CFG_CODE_FIRST, KEYPAD_LEGEND[k]);
                    write_reg(CFG_CODE_SECOND, KEYPAD_LEGEND[k]);
                end
                5: begin
                    write_reg(CFG_CODE_FIRST, CODE_W'($urandom_range(0, 127)));
                    write_reg(CFG_CODE_SECOND, CODE_W'($urandom_range(0, 127)));
                    write_reg(CFG_SPARE_LO, CODE_W'($urandom_range(0, 127)));
                    write_reg(CFG_SPARE_HI, CODE_W'($urandom_range(0, 127)));
                end
                default: begin
                    write_reg(CFG_CODE_FIRST, RESET_CODE_FIRST);
                    write_reg(CFG_CODE_SECOND, RESET_CODE_SECOND);
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) begin
                    burst = ($urandom_range(0, 3) == 0);
                end
                send_random_scan();
            end
            wait_drained();
        end

        if (sb.failures == 0) begin
            $display("** keypad_edge_scanner_pin_check_top: PASSED **");
        end else begin
            $display("** keypad_edge_scanner_pin_check_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timed out", $time);
        $display("** keypad_edge_scanner_pin_check_top: FAILED **");
        $finish;
    end

endmodule
